@@ rtl/blg_pkg.sv @@
`timescale 1ns / 1ps
package blg_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned RATIO_W  = 10;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned KIND_W   = 2;

  // divider geometry: (avg - floor) * 105 needs 17 bits, max - floor fits 10 bits
  localparam int unsigned DIV_NUM_W = 17;
  localparam int unsigned DIV_DEN_W = 10;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [SAMPLE_W-1:0] GAUGE_FLOOR     = 12'd3200;
  localparam logic [PCT_W-1:0]    GAUGE_OVERSHOOT = 7'd105;
  localparam logic [PCT_W-1:0]    PCT_MAX         = 7'd100;
  localparam logic [RATIO_W-1:0]  RATIO_FULL      = 10'd500;
  localparam logic [RATIO_W-1:0]  RATIO_CHARGING  = 10'd10;
  localparam logic [RATIO_W-1:0]  RATIO_STEP_UP   = 10'd5;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PERCENT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHARGING = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_AVG_WAIT,
    ST_MUL,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_PUSH
  } blg_state_e;

  typedef struct packed {
    logic step;
    logic avg_start;
    logic avg_take;
    logic mul;
    logic pct_start;
    logic pct_take;
    logic push;
  } blg_cmd_t;

  typedef struct packed {
    logic group_done;
    logic above_floor;
    logic div_done;
    logic out_free;
  } blg_sts_t;

endpackage

@@ rtl/blg_div.sv @@
`timescale 1ns / 1ps
module blg_div
  import blg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;

  logic [DIV_DEN_W:0] rem_sh;
  logic [DIV_DEN_W:0] rem_diff;
  logic               fits;

  // one restoring step per cycle, msb first
  assign rem_sh   = {rem_q, quo_q[DIV_NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign fits     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W);
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/blg_ctrl.sv @@
`timescale 1ns / 1ps
module blg_ctrl
  import blg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  blg_sts_t sts_i,
  output blg_cmd_t cmd_o
);

  blg_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = sts_i.group_done ? ST_AVG_WAIT : ST_PUSH;
      end
      ST_AVG_WAIT: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = sts_i.above_floor ? ST_PCT_GO : ST_PUSH;
      end
      ST_PCT_GO: begin
        state_d = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (sts_i.div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
      end
      ST_DECIDE:   cmd_o.avg_start = sts_i.group_done;
      ST_AVG_WAIT: cmd_o.avg_take  = 1'b1;
      ST_MUL:      cmd_o.mul       = 1'b1;
      ST_PCT_GO:   cmd_o.pct_start = 1'b1;
      ST_PCT_WAIT: cmd_o.pct_take  = sts_i.div_done;
      ST_PUSH:     cmd_o.push      = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/blg_dp.sv @@
`timescale 1ns / 1ps
module blg_dp
  import blg_pkg::*;
#(
  parameter int unsigned AVG_SAMPLES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                usb_present_i,
  input  logic                charger_active_i,
  input  logic                sample_valid_i,
  input  logic [SAMPLE_W-1:0] adc_sample_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   report_kind_o,
  output logic [PCT_W-1:0]    percent_level_o,
  output logic [SAMPLE_W-1:0] adc_average_o,
  output logic [SAMPLE_W-1:0] full_scale_o,
  input  blg_cmd_t            cmd_i,
  output blg_sts_t            sts_o
);

  localparam logic [CNT_W-1:0] AVG_CNT = CNT_W'(AVG_SAMPLES);

  // group average as a reciprocal multiply, exact for every 16-bit sum
  localparam int unsigned AVG_SH  = $clog2(AVG_SAMPLES);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << (SUM_W + AVG_SH)) + AVG_SAMPLES - 1) / AVG_SAMPLES);

  logic [RATIO_W-1:0]   ratio_q, ratio_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SAMPLE_W-1:0]  max_q, max_d;
  logic [SAMPLE_W-1:0]  avg_q, avg_d;
  logic [SUM_W-1:0]     hold_q, hold_d;
  logic                 group_q, group_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [PCT_W-1:0]     pct_q, pct_d;
  logic [DIV_NUM_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0]    avg_prod_q, avg_prod_d;

  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   out_kind_q;
  logic [PCT_W-1:0]    out_pct_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic [SAMPLE_W-1:0] out_max_q;

  logic [SUM_W-1:0]     base_sum, new_sum;
  logic [CNT_W-1:0]     base_cnt, new_cnt;
  logic [SAMPLE_W-1:0]  avg_over, max_over;
  logic [SAMPLE_W-1:0]  new_avg;
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  assign avg_over = avg_q - GAUGE_FLOOR;
  assign max_over = max_q - GAUGE_FLOOR;
  assign new_avg  = avg_prod_q[SUM_W+AVG_SH +: SAMPLE_W];

  always_comb begin
    ratio_d    = ratio_q;
    sum_d      = sum_q;
    count_d    = count_q;
    max_d      = max_q;
    avg_d      = avg_q;
    hold_d     = hold_q;
    group_d    = group_q;
    kind_d     = kind_q;
    pct_d      = pct_q;
    prod_d     = prod_q;
    avg_prod_d = avg_prod_q;
    base_sum   = sum_q;
    base_cnt   = count_q;
    new_sum    = '0;
    new_cnt    = '0;

    if (cfg_we_i) begin
      max_d = (cfg_wdata_i < GAUGE_FLOOR) ? GAUGE_FLOOR : cfg_wdata_i;
    end

    if (cmd_i.step) begin
      kind_d  = KIND_NONE;
      pct_d   = '0;
      group_d = 1'b0;
      if (usb_present_i) begin
        // ratio counter: slow walk down while charging, fast walk up otherwise
        if (charger_active_i) begin
          if (ratio_q > RATIO_W'(1)) ratio_d = ratio_q - RATIO_W'(1);
        end else if (ratio_q <= RATIO_FULL) begin
          ratio_d = ratio_q + RATIO_STEP_UP;
        end
        if (ratio_d > RATIO_FULL) begin
          kind_d = KIND_FULL;
          max_d  = GAUGE_FLOOR;
        end
        if (ratio_d < RATIO_CHARGING) kind_d = KIND_CHARGING;
      end else begin
        // usb just removed: restart the averaging group
        if (ratio_q != '0) begin
          ratio_d  = '0;
          base_sum = '0;
          base_cnt = '0;
        end
        sum_d   = base_sum;
        count_d = base_cnt;
        if (sample_valid_i) begin
          new_sum = base_sum + SUM_W'(adc_sample_i);
          new_cnt = base_cnt + CNT_W'(1);
          if (new_cnt >= AVG_CNT) begin
            group_d = 1'b1;
            hold_d  = new_sum;
            sum_d   = '0;
            count_d = '0;
          end else begin
            sum_d   = new_sum;
            count_d = new_cnt;
          end
        end
      end
    end

    if (cmd_i.avg_start) begin
      avg_prod_d = PROD_W'(hold_q) * PROD_W'(AVG_RECIP);
    end

    if (cmd_i.avg_take) begin
      avg_d  = new_avg;
      kind_d = KIND_PERCENT;
      if (max_q < new_avg) max_d = new_avg;
    end

    if (cmd_i.mul) begin
      prod_d = DIV_NUM_W'(avg_over[DIV_DEN_W-1:0]) * DIV_NUM_W'(GAUGE_OVERSHOOT);
    end

    if (cmd_i.pct_take) begin
      pct_d = (div_quot > DIV_NUM_W'(PCT_MAX)) ? PCT_MAX : div_quot[PCT_W-1:0];
    end
  end

  // divider: scaled level by span
  assign div_start = cmd_i.pct_start;
  assign div_num   = prod_q;
  assign div_den   = max_over[DIV_DEN_W-1:0];

  blg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.push)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q     <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      max_q       <= GAUGE_FLOOR;
      avg_q       <= '0;
      group_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ratio_q     <= ratio_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      max_q       <= max_d;
      avg_q       <= avg_d;
      group_q     <= group_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    kind_q     <= kind_d;
    pct_q      <= pct_d;
    prod_q     <= prod_d;
    avg_prod_q <= avg_prod_d;
    if (cmd_i.push) begin
      out_kind_q <= kind_q;
      out_pct_q  <= pct_q;
      out_avg_q  <= avg_q;
      out_max_q  <= max_q;
    end
  end

  assign sts_o.group_done  = group_q;
  assign sts_o.above_floor = avg_q > GAUGE_FLOOR;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign report_kind_o   = out_kind_q;
  assign percent_level_o = out_pct_q;
  assign adc_average_o   = out_avg_q;
  assign full_scale_o    = out_max_q;

endmodule

@@ rtl/battery_level_gauge_unit.sv @@
`timescale 1ns / 1ps
// battery level gauge: each input beat (usb present, charger pin, sample flag and
// 12-bit converter reading) produces exactly one output beat carrying a report kind
// (none, percent, full, charging), the percent level, the latest averaged reading and
// the tracked full-scale value. with usb present a ratio counter follows the charger
// pin and reports full or charging; without usb, flagged samples are summed in groups
// of AVG_SAMPLES and each completed group yields an average and a percent level
// (avg - 3200) * 105 / (max - 3200) clamped to 0..100. a beat that does not close a
// group goes from acceptance through a decide step straight to the push. a beat that
// closes a group averages by a reciprocal multiply; at or below 3200 it then goes to
// the push, above it the 17-step restoring divider for the percent runs first. one
// beat is in work at a time; a full output register that is not being read holds the
// final push, and it lets the next beat enter while a result waits. writing cfg_wdata_i
// loads the full-scale reference (raised to at least 3200).
module battery_level_gauge_unit
  import blg_pkg::*;
#(
  parameter int unsigned AVG_SAMPLES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: full-scale reference
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // usb_present, charger_active, adc_sample[11:0], pad
  input  logic        s_axis_tuser,  // sample_valid
  // output beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // percent_level[6:0], adc_average[11:0],
                                     // full_scale[11:0], pad
  output logic [1:0]  m_axis_tuser   // report_kind
);

  blg_cmd_t cmd;
  blg_sts_t sts;

  logic [PCT_W-1:0]    percent_level;
  logic [SAMPLE_W-1:0] adc_average;
  logic [SAMPLE_W-1:0] full_scale;

  // sequencing: accept, decide, average, scale, divide, push
  blg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // gauge state, averager, divider and output register
  blg_dp #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .usb_present_i   (s_axis_tdata[0]),
    .charger_active_i(s_axis_tdata[1]),
    .sample_valid_i  (s_axis_tuser),
    .adc_sample_i    (s_axis_tdata[13:2]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .report_kind_o   (m_axis_tuser),
    .percent_level_o (percent_level),
    .adc_average_o   (adc_average),
    .full_scale_o    (full_scale),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  // pack output fields from the lowest bit up
  assign m_axis_tdata = {1'b0, full_scale, adc_average, percent_level};

  // percent never exceeds 100
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (percent_level <= PCT_MAX))
    else $error("percent level above 100");

  // only a percent report carries a nonzero level
  a_pct_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_PERCENT)) |-> (percent_level == '0))
    else $error("nonzero percent on a non-percent report");

  // full scale never drops below the floor
  a_fs_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (full_scale >= GAUGE_FLOOR))
    else $error("full scale below floor");

  // one beat in work at a time
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while busy");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import blg_pkg::*;

  localparam int unsigned GROUP_LEN  = 16;
  localparam int unsigned STALL_MAX  = 5000;  // cycles with work pending and no beat moving
  localparam int unsigned TAIL_WAIT  = 60;    // beyond the slowest group-closing beat
  localparam int unsigned MAX_SHOWN  = 10;

  // one queued action for the driver: an input beat or a register write
  typedef struct {
    bit          is_cfg;
    logic [11:0] cfg_val;
    logic        usb;
    logic        chg;
    logic        vld;
    logic [11:0] sample;
  } gauge_beat_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PCT_W-1:0]  pct;
    logic [11:0]       avg;
    logic [11:0]       full_scale;
  } gauge_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // usb_present, charger_active, adc_sample[11:0], pad
  logic        s_axis_tuser = 1'b0; // sample_valid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // percent_level[6:0], adc_average[11:0], full_scale[11:0], pad
  logic [1:0]  m_axis_tuser;        // report_kind

  battery_level_gauge_unit #(
    .AVG_SAMPLES(GROUP_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  gauge_beat_t   pending_q[$];
  gauge_report_t report_q[$];

  // idle odds in percent, changed per phase by the sequence below
  int unsigned src_idle_pct  = 9;
  int unsigned sink_idle_pct = 56;

  int unsigned mismatches = 0;
  int unsigned beats_in   = 0;
  int unsigned beats_out  = 0;
  int unsigned cfg_writes = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};

  // gauge model state
  logic [RATIO_W-1:0]  ratio_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [11:0]         max_q;
  logic [11:0]         avg_q;

  function automatic gauge_report_t gauge_predict(input gauge_beat_t b);
    gauge_report_t r;
    int            num;
    int            den;
    int            p;
    r.kind = KIND_NONE;
    r.pct  = '0;
    if (b.usb) begin
      // ratio counter: down while charging (floor 1), up by a step until past full
      if (b.chg) begin
        if (ratio_q > RATIO_W'(1)) ratio_q = ratio_q - RATIO_W'(1);
      end else if (ratio_q <= RATIO_FULL) begin
        ratio_q = ratio_q + RATIO_STEP_UP;
      end
      if (ratio_q > RATIO_FULL) begin
        r.kind = KIND_FULL;
        max_q  = GAUGE_FLOOR;
      end
      if (ratio_q < RATIO_CHARGING) r.kind = KIND_CHARGING;
    end else begin
      // usb just gone: the group restarts
      if (ratio_q != '0) begin
        ratio_q = '0;
        sum_q   = '0;
        cnt_q   = '0;
      end
      if (b.vld) begin
        sum_q = sum_q + SUM_W'(b.sample);
        cnt_q = cnt_q + CNT_W'(1);
        if (cnt_q >= CNT_W'(GROUP_LEN)) begin
          avg_q = 12'(sum_q / GROUP_LEN);
          if (max_q < avg_q) max_q = avg_q;
          if (avg_q > GAUGE_FLOOR && max_q > GAUGE_FLOOR) begin
            num = (int'(avg_q) - int'(GAUGE_FLOOR)) * int'(GAUGE_OVERSHOOT);
            den = int'(max_q) - int'(GAUGE_FLOOR);
            p   = num / den;
            r.pct = (p > int'(PCT_MAX)) ? PCT_MAX : PCT_W'(p);
          end
          r.kind = KIND_PERCENT;
          sum_q  = '0;
          cnt_q  = '0;
        end
      end
    end
    r.avg        = avg_q;
    r.full_scale = max_q;
    return r;
  endfunction

  // driver: presents queued beats and register writes, updates the model on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    gauge_beat_t b;
    logic        cfg_we;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
      ratio_q       = '0;
      sum_q         = '0;
      cnt_q         = '0;
      avg_q         = '0;
      max_q         = GAUGE_FLOOR;
    end else begin
      cfg_we = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        b.is_cfg  = 1'b0;
        b.cfg_val = '0;
        b.usb     = s_axis_tdata[0];
        b.chg     = s_axis_tdata[1];
        b.sample  = s_axis_tdata[13:2];
        b.vld     = s_axis_tuser;
        report_q.push_back(gauge_predict(b));
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
          // only queued once the block has drained
          b = pending_q.pop_front();
          cfg_we        = 1'b1;
          cfg_wdata_i   <= b.cfg_val;
          max_q         = (b.cfg_val < GAUGE_FLOOR) ? GAUGE_FLOOR : b.cfg_val;
          cfg_writes++;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          b = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, b.sample, b.chg, b.usb};
          s_axis_tuser  <= b.vld;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      cfg_we_i <= cfg_we;
    end
  end

  // monitor: compares each output beat with the oldest predicted report
  always @(posedge clk_i or negedge rst_ni) begin
    gauge_report_t want;
    gauge_report_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = m_axis_tuser;
        got.pct        = m_axis_tdata[6:0];
        got.avg        = m_axis_tdata[18:7];
        got.full_scale = m_axis_tdata[30:19];
        beats_out++;
        kind_seen[got.kind]++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: output beat with no report pending: kind %0d pct %0d avg %0d fs %0d",
                     $realtime, got.kind, got.pct, got.avg, got.full_scale);
        end else begin
          want = report_q.pop_front();
          if (got.kind !== want.kind || got.pct !== want.pct || got.avg !== want.avg ||
              got.full_scale !== want.full_scale) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: report %0d mismatch: kind %0d/%0d pct %0d/%0d avg %0d/%0d fs %0d/%0d",
                       $realtime, beats_out, want.kind, got.kind, want.pct, got.pct,
                       want.avg, got.avg, want.full_scale, got.full_scale);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // watchdog: only counts while some beat or report is outstanding
  int unsigned stall_cnt = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_q.size() == 0 && !s_axis_tvalid && report_q.size() == 0)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_MAX);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic queue_beat(input logic usb, input logic chg, input logic vld,
                            input logic [11:0] sample);
    gauge_beat_t b;
    b.is_cfg  = 1'b0;
    b.cfg_val = '0;
    b.usb     = usb;
    b.chg     = chg;
    b.vld     = vld;
    b.sample  = sample;
    pending_q.push_back(b);
  endtask

  task automatic queue_cfg(input logic [11:0] val);
    gauge_beat_t b;
    b.is_cfg  = 1'b1;
    b.cfg_val = val;
    b.usb     = 1'b0;
    b.chg     = 1'b0;
    b.vld     = 1'b0;
    b.sample  = '0;
    pending_q.push_back(b);
  endtask

  // hold off until everything sent has been answered
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
  endtask

  // mostly well-formed traffic: usb sessions that walk the ratio counter and
  // battery runs of mostly flagged samples, with some raw noise mixed in
  task automatic queue_random(input int unsigned n_beats);
    int unsigned done_cnt;
    int unsigned pick;
    int unsigned len;
    int unsigned chg_pct;
    int unsigned vld_pct;
    int          base;
    int          s;
    done_cnt = 0;
    while (done_cnt < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 140);
        case ($urandom_range(0, 2))
          0: chg_pct = 4;
          1: chg_pct = 50;
          default: chg_pct = 90;
        endcase
        repeat (len)
          queue_beat(1'b1, $urandom_range(0, 99) < chg_pct, 1'($urandom), 12'($urandom));
        done_cnt += len;
      end else if (pick < 88) begin
        len     = $urandom_range(4, 40);
        vld_pct = ($urandom_range(0, 3) == 0) ? 60 : 95;
        // usually near full scale so the percent spans its range
        base    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(3100, 4095);
        repeat (len) begin
          s = base + $urandom_range(0, 240) - 120;
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          queue_beat(1'b0, 1'($urandom), $urandom_range(0, 99) < vld_pct, 12'(s));
        end
        done_cnt += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len)
          queue_beat(1'($urandom), 1'($urandom), 1'($urandom), 12'($urandom));
        done_cnt += len;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    #1;
    rst_ni = 1'b1;
    src_idle_pct  = 9;
    sink_idle_pct = 56;

    // directed: ratio counter edges around the charging threshold
    queue_cfg(GAUGE_FLOOR);
    queue_beat(1'b1, 1'b1, 1'b1, 12'hfff);  // counter held at zero while charging
    queue_beat(1'b1, 1'b0, 1'b0, 12'h000);  // up to 5
    queue_beat(1'b1, 1'b0, 1'b1, 12'h000);  // up to 10, report kind none
    queue_beat(1'b1, 1'b1, 1'b0, 12'hfff);  // back to 9, charging
    queue_beat(1'b0, 1'b0, 1'b0, 12'h000);  // usb removed, counter cleared
    // a full group of the largest reading: new maximum, percent clamped
    repeat (GROUP_LEN) queue_beat(1'b0, 1'b1, 1'b1, 12'hfff);
    queue_beat(1'b0, 1'b0, 1'b1, 12'h000);
    queue_beat(1'b0, 1'b1, 1'b1, 12'h000);
    queue_beat(1'b1, 1'b0, 1'b0, 12'h000);
    // usb removed with a valid sample: first of a fresh group
    queue_beat(1'b0, 1'b0, 1'b1, 12'h000);
    drain();

    queue_random(250);
    drain();  // sender hold-off with nothing outstanding
    queue_random(250);
    drain();

    src_idle_pct  = 56;
    sink_idle_pct = 9;
    queue_cfg(12'hfff);
    queue_random(500);
    drain();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    queue_cfg(12'h000);  // below the floor, loads as 3200
    queue_random(250);
    drain();

    queue_cfg(12'($urandom_range(3201, 4094)));
    queue_random(250);
    drain();

    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("run: %0d beats in, %0d reports out, %0d register writes", beats_in, beats_out,
             cfg_writes);
    $display("reports by kind: none %0d, percent %0d, full %0d, charging %0d; %0d mismatches",
             kind_seen[KIND_NONE], kind_seen[KIND_PERCENT], kind_seen[KIND_FULL],
             kind_seen[KIND_CHARGING], mismatches);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
